[sv/dns_catchall_answer_builder_defines.svh]
// Assertion macros for the DNS catch-all answer builder
`ifndef DNS_CATCHALL_ANSWER_BUILDER_DEFINES_SVH
`define DNS_CATCHALL_ANSWER_BUILDER_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define DCAB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define DCAB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dcab_pkg.sv]
// Shared types, constants and byte functions for the DNS catch-all answer builder
package dcab_pkg;

    localparam int BUFFER_BYTES = 512;
    localparam int HDR_BYTES    = 12;
    localparam int QTAIL_BYTES  = 5;
    localparam int ANSWER_BYTES = 16;
    localparam int QUEUE_DEPTH  = 4;

    localparam int CNT_W   = $clog2(BUFFER_BYTES + 1);
    localparam int POS_W   = $clog2(BUFFER_BYTES + 256 + 1);
    localparam int IDX_W   = $clog2(ANSWER_BYTES);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = 32;

    localparam logic [7:0] FLAGS_HI  = 8'h81;
    localparam logic [7:0] FLAGS_LO  = 8'h80;
    localparam logic [7:0] COUNT_ONE = 8'h01;
    localparam logic [7:0] PTR_HI    = 8'hC0;
    localparam logic [7:0] PTR_LO    = 8'h0C;
    localparam logic [7:0] TTL_LO    = 8'h3C;
    localparam logic [7:0] RDLEN_LO  = 8'h04;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       fin;
        logic       ok;
    } cmd_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef enum logic {
        ST_PASS,
        ST_ANSWER
    } back_state_t;

    function automatic logic [7:0] header_byte(input logic [CNT_W-1:0] idx,
                                               input logic [7:0] b);
        logic [7:0] r;
        r = b;
        unique case (idx)
            CNT_W'(2):  r = FLAGS_HI;
            CNT_W'(3):  r = FLAGS_LO;
            CNT_W'(5):  r = COUNT_ONE;
            CNT_W'(7):  r = COUNT_ONE;
            CNT_W'(4), CNT_W'(6), CNT_W'(8), CNT_W'(9), CNT_W'(10), CNT_W'(11):
                r = 8'h00;
            default:    r = b;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] answer_byte(input logic [IDX_W-1:0] idx,
                                               input logic [ADDR_W-1:0] addr);
        logic [7:0] r;
        r = 8'h00;
        unique case (idx)
            IDX_W'(0):  r = PTR_HI;
            IDX_W'(1):  r = PTR_LO;
            IDX_W'(3):  r = COUNT_ONE;
            IDX_W'(5):  r = COUNT_ONE;
            IDX_W'(9):  r = TTL_LO;
            IDX_W'(11): r = RDLEN_LO;
            IDX_W'(12): r = addr[7:0];
            IDX_W'(13): r = addr[15:8];
            IDX_W'(14): r = addr[23:16];
            IDX_W'(15): r = addr[31:24];
            default:    r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

[sv/dcab_front.sv]
// Front end: walks the query, classifies each byte and issues commands
module dcab_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          full,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          cmd_wr,
    output dcab_pkg::cmd_t cmd
);
    import dcab_pkg::*;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [POS_W-1:0] next_label_reg, next_label_next;
    logic             term_reg, term_next;
    logic [POS_W-1:0] qend_reg, qend_next;

    logic             accept;
    logic             in_buf;
    logic [POS_W-1:0] pos;
    logic             at_label;
    logic             is_zero;
    logic             pass;
    logic             ok;

    always_comb
    begin
        accept          = push && !full;
        in_buf          = byte_count_reg < CNT_W'(BUFFER_BYTES);
        pos             = POS_W'(byte_count_reg);
        is_zero         = in_byte == 8'd0;
        at_label        = in_buf && !term_reg && (pos == next_label_reg);
        term_next       = term_reg || (at_label && is_zero);
        qend_next       = (at_label && is_zero) ? pos + POS_W'(QTAIL_BYTES) : qend_reg;
        next_label_next = (at_label && !is_zero)
                          ? pos + POS_W'(in_byte) + POS_W'(1) : next_label_reg;
        byte_count_next = in_buf ? byte_count_reg + CNT_W'(1) : byte_count_reg;
        pass            = in_buf && (!term_next || (pos < qend_next));
        ok              = (byte_count_next >= CNT_W'(HDR_BYTES)) && term_next
                          && (qend_next <= POS_W'(byte_count_next))
                          && (qend_next <= POS_W'(BUFFER_BYTES - ANSWER_BYTES));
        cmd.emit        = pass && (!in_last || ok);
        cmd.data        = header_byte(byte_count_reg, in_byte);
        cmd.fin         = in_last;
        cmd.ok          = ok;
        cmd_wr          = accept && (pass || in_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            next_label_reg <= POS_W'(HDR_BYTES);
            term_reg       <= 1'b0;
            qend_reg       <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                byte_count_reg <= '0;
                next_label_reg <= POS_W'(HDR_BYTES);
                term_reg       <= 1'b0;
                qend_reg       <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                next_label_reg <= next_label_next;
                term_reg       <= term_next;
                qend_reg       <= qend_next;
            end
        end
    end

endmodule

[sv/dcab_queue.sv]
// Short command queue between the front end and the back end
module dcab_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  dcab_pkg::cmd_t  wr_data,
    input  logic            rd_en,
    output dcab_pkg::cmd_t  rd_data,
    output dcab_pkg::q_stat_t stat
);
    import dcab_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    always_comb
    begin
        stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
        stat.empty = count_reg == '0;
        stat.count = count_reg;
        do_wr      = wr_en && !stat.full;
        do_rd      = rd_en && !stat.empty;
        rd_data    = mem_reg[rd_ptr_reg];
        count_next = count_reg + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[sv/dcab_back.sv]
// Back end: expands commands into response bytes and the answer record
module dcab_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dcab_pkg::cmd_t            head,
    input  logic                      q_empty,
    output logic                      q_pop,
    input  logic [dcab_pkg::ADDR_W-1:0] addr,
    input  logic                      pop,
    output logic                      empty,
    output logic [7:0]                out_byte,
    output logic                      out_last,
    output logic                      out_drop
);
    import dcab_pkg::*;

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             drop_reg, drop_next;
    logic             adv;
    logic             load;

    always_comb
    begin
        adv        = !valid_reg || pop;
        load       = 1'b0;
        q_pop      = 1'b0;
        state_next = state_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        drop_next  = drop_reg;
        unique case (state_reg)
            ST_PASS:
            begin
                if (adv && !q_empty)
                begin
                    load  = 1'b1;
                    q_pop = 1'b1;
                    if (head.emit)
                    begin
                        byte_next = head.data;
                        last_next = 1'b0;
                        drop_next = 1'b0;
                        if (head.fin)
                        begin
                            state_next = ST_ANSWER;
                            idx_next   = '0;
                        end
                    end
                    else if (!head.ok)
                    begin
                        byte_next = 8'h00;
                        last_next = 1'b1;
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        byte_next  = answer_byte('0, addr);
                        last_next  = 1'b0;
                        drop_next  = 1'b0;
                        state_next = ST_ANSWER;
                        idx_next   = IDX_W'(1);
                    end
                end
            end
            ST_ANSWER:
            begin
                if (adv)
                begin
                    load      = 1'b1;
                    byte_next = answer_byte(idx_reg, addr);
                    last_next = idx_reg == IDX_W'(ANSWER_BYTES - 1);
                    drop_next = 1'b0;
                    idx_next  = idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(ANSWER_BYTES - 1))
                    begin
                        state_next = ST_PASS;
                    end
                end
            end
            default:
            begin
                state_next = ST_PASS;
            end
        endcase
        valid_next = load ? 1'b1 : (pop ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PASS;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        drop_reg <= drop_next;
    end

    assign empty    = !valid_reg;
    assign out_byte = byte_reg;
    assign out_last = last_reg;
    assign out_drop = drop_reg;

endmodule

[sv/dns_catchall_answer_builder.sv]
// Top level of the DNS catch-all answer builder
// A query byte reaches the result ports through the command queue and the back-end
// output register. Throughput: one byte per cycle while the result side pops; a valid
// final byte adds 16 answer bytes, one per cycle from the back-end sequencer, while the
// four-entry command queue takes up to four more bytes before full stalls the input.
// Reset: rst_n clears all control state and the answer address; no clearing pass.
module dns_catchall_answer_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_drop,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import dcab_pkg::*;

    `include "dns_catchall_answer_builder_defines.svh"

    cmd_t              wr_cmd;
    cmd_t              head;
    logic              cmd_wr;
    logic              q_pop;
    q_stat_t           q_stat;
    logic [ADDR_W-1:0] addr_reg;

    assign cfg_ready = 1'b1;
    assign full      = q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            addr_reg <= cfg_data;
        end
    end

    dcab_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (q_stat.full),
        .in_byte (in_byte),
        .in_last (in_last),
        .cmd_wr  (cmd_wr),
        .cmd     (wr_cmd)
    );

    dcab_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (wr_cmd),
        .rd_en   (q_pop),
        .rd_data (head),
        .stat    (q_stat)
    );

    dcab_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_stat.empty),
        .q_pop    (q_pop),
        .addr     (addr_reg),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .out_last (out_last),
        .out_drop (out_drop)
    );

    `DCAB_ASSERT_NOW(a_drop_is_last, !empty && out_drop, out_last, "drop result without last")
    `DCAB_ASSERT_NOW(a_drop_is_zero, !empty && out_drop, out_byte == 8'h00, "drop byte not zero")
    `DCAB_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overrun")
    `DCAB_ASSERT_NOW(a_pop_needs_entry, q_pop, !q_stat.empty, "pop from empty queue")

endmodule

[bench/tb_dns_catchall_answer_builder.sv]
// Self-checking testbench for the DNS catch-all answer builder
`timescale 1ns / 100ps

module tb_dns_catchall_answer_builder;

    localparam int          QUERY_BUF    = 512;
    localparam int          HEADER_LEN   = 12;
    localparam int          QTAIL_LEN    = 5;
    localparam int          ANSWER_LEN   = 16;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          SETTLE_TICKS = 8;
    localparam int          PHASE_BYTES  = 20;
    localparam logic [15:0] REPLY_FLAGS  = 16'h8180;
    localparam logic [15:0] NAME_PTR     = 16'hC00C;
    localparam logic [15:0] RR_TYPE_A    = 16'd1;
    localparam logic [15:0] RR_CLASS_IN  = 16'd1;
    localparam logic [31:0] ANSWER_TTL   = 32'd60;
    localparam logic [15:0] ANSWER_RDLEN = 16'd4;

    typedef enum int {POP_FREE, POP_RANDOM, POP_SPARSE, POP_BURSTY} pop_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       drop;
    } reply_t;

    class dns_reply_predictor_t;
        logic [31:0] answer_addr;
        int unsigned rx_count;
        int unsigned label_pos;
        bit          name_done;
        int unsigned qtail_stop;
        reply_t      pending_replies[$];
        int          errors;

        function new();
            answer_addr = '0;
            errors      = 0;
            clear_query();
        endfunction

        function void clear_query();
            rx_count   = 0;
            label_pos  = HEADER_LEN;
            name_done  = 1'b0;
            qtail_stop = 0;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void expect_reply(logic [7:0] d, logic f, logic dr);
            reply_t r;
            r.data = d;
            r.fin  = f;
            r.drop = dr;
            pending_replies.push_back(r);
        endfunction

        function logic [7:0] reply_header(int unsigned idx, logic [7:0] b);
            logic [95:0] hdr;
            hdr = {16'h0000, REPLY_FLAGS, 16'd1, 16'd1, 16'd0, 16'd0};
            if (idx < 2 || idx >= HEADER_LEN)
                return b;
            return hdr[95 - 8 * idx -: 8];
        endfunction

        function void note_query_byte(logic [7:0] b, logic fin);
            int unsigned idx;
            bit          echo;
            bit          valid;
            logic [7:0]  echo_byte;
            logic [127:0] ans;
            echo      = 1'b0;
            echo_byte = '0;
            if (rx_count < QUERY_BUF)
            begin
                idx = rx_count;
                if (!name_done && idx == label_pos)
                begin
                    if (b == 8'h00)
                    begin
                        name_done  = 1'b1;
                        qtail_stop = idx + QTAIL_LEN;
                    end
                    else
                        label_pos = idx + b + 1;
                end
                rx_count = idx + 1;
                if (!name_done || idx < qtail_stop)
                begin
                    echo      = 1'b1;
                    echo_byte = reply_header(idx, b);
                end
            end
            if (!fin)
            begin
                if (echo)
                    expect_reply(echo_byte, 1'b0, 1'b0);
                return;
            end
            valid = rx_count >= HEADER_LEN && name_done && qtail_stop <= rx_count
                    && qtail_stop <= QUERY_BUF - ANSWER_LEN;
            if (!valid)
                expect_reply(8'h00, 1'b1, 1'b1);
            else
            begin
                if (echo)
                    expect_reply(echo_byte, 1'b0, 1'b0);
                ans = {NAME_PTR, RR_TYPE_A, RR_CLASS_IN, ANSWER_TTL, ANSWER_RDLEN,
                       answer_addr[7:0], answer_addr[15:8], answer_addr[23:16],
                       answer_addr[31:24]};
                for (int k = 0; k < ANSWER_LEN; k++)
                    expect_reply(ans[127 - 8 * k -: 8], k == ANSWER_LEN - 1, 1'b0);
            end
            clear_query();
        endfunction

        function void check_reply_byte(logic [7:0] d, logic f, logic dr);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result out_byte=%02h out_last=%0b out_drop=%0b",
                         $time, d, f, dr);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (d !== want.data)
            begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, d);
                errors++;
            end
            if (f !== want.fin)
            begin
                $display("%0t: out_last expected %0b actual %0b", $time, want.fin, f);
                errors++;
            end
            if (dr !== want.drop)
            begin
                $display("%0t: out_drop expected %0b actual %0b", $time, want.drop, dr);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        out_drop;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    dns_reply_predictor_t replies;
    logic [7:0]           pkt[$];
    int unsigned          burst_left;
    int unsigned          sent_bytes;
    int unsigned          cycles;

    dns_catchall_answer_builder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_drop  (out_drop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** dns_catchall_answer_builder: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            replies.check_reply_byte(out_byte, out_last, out_drop);
    end

    initial
    begin : rx_stall
        pop_mode_t   mode;
        int unsigned span;
        int unsigned tick;
        pop  = 1'b0;
        mode = POP_FREE;
        span = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                mode = pop_mode_t'($urandom_range(0, 3));
                span = $urandom_range(16, 80);
            end
            span--;
            tick++;
            case (mode)
                POP_FREE:   pop <= 1'b1;
                POP_RANDOM: pop <= ($urandom_range(0, 2) != 0);
                POP_SPARSE: pop <= (tick % 4 == 0);
                default:    pop <= (tick % 16 < 11);
            endcase
        end
    end

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push    <= 1'b1;
        in_byte <= b;
        in_last <= fin;
        do
            @(posedge clk);
        while (full);
        replies.note_query_byte(b, fin);
        sent_bytes++;
        @(negedge clk);
    endtask

    task automatic send_packet();
        foreach (pkt[k])
            send_byte(pkt[k], k == pkt.size() - 1);
    endtask

    task automatic add_random(input int n);
        repeat (n) pkt.push_back(8'($urandom));
    endtask

    task automatic add_label(input int len);
        pkt.push_back(8'(len));
        add_random(len);
    endtask

    task automatic add_fill(input logic [7:0] v, input int n);
        repeat (n) pkt.push_back(v);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (replies.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_answer_address(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        replies.answer_addr = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_packet();
        int unsigned kind;
        int unsigned nlab;
        int unsigned cut;
        kind = $urandom_range(0, 9);
        pkt  = {};
        if (kind == 7)
            add_random($urandom_range(1, 24));
        else
        begin
            add_random(HEADER_LEN);
            nlab = $urandom_range(1, 3);
            repeat (nlab) add_label($urandom_range(1, 12));
            pkt.push_back(8'h00);
            add_random(4);
            if ($urandom_range(0, 1))
                add_random($urandom_range(1, 4));
            if (kind >= 8)
            begin
                cut = $urandom_range(1, pkt.size() - 1);
                pkt = pkt[0:cut-1];
            end
        end
        send_packet();
    endtask

    initial
    begin : stimulus
        logic [31:0] addr_plan[3];
        int unsigned target;
        replies    = new();
        rst_n      = 1'b0;
        push       = 1'b0;
        in_byte    = 8'h00;
        in_last    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 32'h0;
        burst_left = 0;
        sent_bytes = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        write_answer_address($urandom);

        pkt = {};
        add_fill(8'h00, HEADER_LEN + QTAIL_LEN);
        send_packet();

        pkt = {8'h5A};
        send_packet();

        pkt = {};
        add_random(HEADER_LEN);
        add_label(3);
        pkt.push_back(8'h00);
        add_random(3);
        send_packet();

        addr_plan[0] = 32'h0000_0000;
        addr_plan[1] = 32'hFFFF_FFFF;
        addr_plan[2] = $urandom;
        foreach (addr_plan[p])
        begin
            drain();
            write_answer_address(addr_plan[p]);
            target = sent_bytes + PHASE_BYTES;
            while (sent_bytes < target)
                send_random_packet();
        end

        drain();
        if (replies.errors == 0 && replies.pending() == 0)
            $display("** dns_catchall_answer_builder: PASSED **");
        else
            $display("** dns_catchall_answer_builder: FAILED **");
        $finish;
    end

endmodule

[dns_catchall_answer_builder.f]
+incdir+sv
sv/dcab_pkg.sv
sv/dcab_front.sv
sv/dcab_queue.sv
sv/dcab_back.sv
sv/dns_catchall_answer_builder.sv
bench/tb_dns_catchall_answer_builder.sv
